// ===== design/aps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants for the adc poll scheduler
// widths, register codes, result layout and channel period reset values
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int NUM_CHANNELS_DEF = 5;
    localparam int REF_MV_DEF       = 2500;

    localparam int CODE_W   = 10;
    localparam int MV_W     = 13;
    localparam int CH_W     = 3;
    localparam int REG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam int NUM_PERIOD_REGS = 5;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [REG_W-1:0] SLOW_PERIOD   = 16'd600;
    localparam logic [REG_W-1:0] FAST_PERIOD   = 16'd52;
    localparam logic [REG_W-1:0] FIXED_PERIOD  = 16'd600;
    localparam logic [REG_W-1:0] RETRY_TICKS   = 16'd100;
    localparam logic [REG_W-1:0] JUMP_MV_RST   = 16'd500;
    localparam logic [REG_W-1:0] HIGH_MV_RST   = 16'd5000;
    localparam logic [REG_W-1:0] LOW_MV_RST    = 16'd3000;
    localparam logic [CH_W-1:0]  BATTERY_CH    = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PERIOD0 = 3'd0,
        REG_PERIOD1 = 3'd1,
        REG_PERIOD2 = 3'd2,
        REG_PERIOD3 = 3'd3,
        REG_PERIOD4 = 3'd4,
        REG_JUMP    = 3'd5,
        REG_HIGH    = 3'd6,
        REG_LOW     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KIND_UNKNOWN   = 2'd0,
        KIND_LITHIUM   = 2'd1,
        KIND_NINE_VOLT = 2'd2
    } t_batt_kind;

    typedef struct packed {
        logic [REG_W-1:0] jump_mv;
        logic [REG_W-1:0] high_mv;
        logic [REG_W-1:0] low_mv;
    } t_thresh;

    // first field in the highest bits
    typedef struct packed {
        logic             battery_tracking;
        logic [1:0]       battery_kind;
        logic [MV_W-1:0]  update_millivolts;
        logic [CH_W-1:0]  update_channel;
        logic             update_valid;
        logic [CH_W-1:0]  start_channel;
        logic             start_conversion;
    } t_result;

    function automatic logic [REG_W-1:0] period_reset(input int ch);
        logic [REG_W-1:0] v;
        case (ch)
            0, 1, 2: v = SLOW_PERIOD;
            3, 4:    v = FAST_PERIOD;
            default: v = FIXED_PERIOD;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== design/aps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aps_front: tick intake
// scales the converter code to millivolts and queues it for the back end
// ----------------------------------------------------------------------------
module aps_front #(
    parameter int REF_MILLIVOLTS = aps_pkg::REF_MV_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [aps_pkg::CODE_W-1:0]     i_code,
    input  wire logic                           i_pop,
    output logic                                o_q_valid,
    output logic [aps_pkg::MV_W-1:0]            o_q_mv
);
    import aps_pkg::*;

    localparam int PROD_W = CODE_W + MV_W;
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    logic [PROD_W-1:0] prod;
    logic [MV_W-1:0]   mv;
    logic              push;

    logic [MV_W-1:0]   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;

    // code * ref >> 10
    assign prod = PROD_W'(i_code) * PROD_W'(REF_MILLIVOLTS);
    assign mv   = prod[CODE_W +: MV_W];

    assign o_s_tready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign push       = i_s_tvalid && o_s_tready;
    assign o_q_valid  = (r_count != '0);
    assign o_q_mv     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= mv;
        end
    end

endmodule
`default_nettype wire

// ===== design/aps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// aps_back: scheduler and battery filter
// runs the channel countdowns, the conversion handshake and the slew filter
// ----------------------------------------------------------------------------
module aps_back #(
    parameter int NUM_CHANNELS = aps_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic [NUM_CHANNELS-1:0][aps_pkg::REG_W-1:0]  i_periods,
    input  wire aps_pkg::t_thresh                             i_thresh,
    input  wire logic                                         i_q_valid,
    input  wire logic [aps_pkg::MV_W-1:0]                     i_q_mv,
    output logic                                              o_pop,
    output logic                                              o_m_tvalid,
    input  wire logic                                         i_m_tready,
    output aps_pkg::t_result                                  o_result
);
    import aps_pkg::*;

    logic [REG_W-1:0] r_cd [NUM_CHANNELS];
    logic [REG_W-1:0] n_cd [NUM_CHANNELS];
    logic [REG_W-1:0] dec  [NUM_CHANNELS];
    logic             r_pending, n_pending;
    logic [CH_W-1:0]  r_pend_ch, n_pend_ch;
    logic [MV_W-1:0]  r_batt_mv, n_batt_mv;
    t_batt_kind       r_class, n_class;
    logic             r_seen, n_seen;
    logic             r_o_valid;
    t_result          r_out;
    t_result          res;

    logic             any_due;
    logic [CH_W-1:0]  sel;
    logic             up;
    logic [MV_W-1:0]  delta;
    logic             advance;

    assign advance    = i_q_valid && (!r_o_valid || i_m_tready);
    assign o_pop      = advance;
    assign o_m_tvalid = r_o_valid;
    assign o_result   = r_out;

    always_comb begin
        n_pending = r_pending;
        n_pend_ch = r_pend_ch;
        n_batt_mv = r_batt_mv;
        n_class   = r_class;
        n_seen    = r_seen;
        res       = '0;
        any_due   = 1'b0;
        sel       = '0;
        up        = 1'b0;
        delta     = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            dec[i]  = (r_cd[i] != '0) ? r_cd[i] - 1'b1 : r_cd[i];
            n_cd[i] = r_cd[i];
        end

        if (!r_pending) begin
            // highest due channel wins
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (dec[i] == '0) begin
                    any_due = 1'b1;
                    sel     = CH_W'(i);
                end
            end
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                n_cd[i] = (any_due && sel == CH_W'(i)) ? i_periods[i] : dec[i];
            end
            if (any_due) begin
                n_pending            = 1'b1;
                n_pend_ch            = sel;
                res.start_conversion = 1'b1;
                res.start_channel    = sel;
            end
        end else begin
            n_pending          = 1'b0;
            res.update_valid   = 1'b1;
            res.update_channel = r_pend_ch;
            if (r_pend_ch == BATTERY_CH) begin
                up    = i_q_mv > r_batt_mv;
                delta = up ? i_q_mv - r_batt_mv : r_batt_mv - i_q_mv;
                if (REG_W'(delta) > i_thresh.jump_mv) begin
                    // large step: take it and retry soon
                    n_batt_mv = i_q_mv;
                    n_cd[0]   = RETRY_TICKS;
                end else begin
                    if (up) begin
                        n_batt_mv = r_batt_mv + 1'b1;
                    end else if (delta != '0) begin
                        n_batt_mv = r_batt_mv - 1'b1;
                    end
                    n_seen = 1'b1;
                    if (REG_W'(n_batt_mv) > i_thresh.high_mv) begin
                        n_class = KIND_NINE_VOLT;
                    end else if (REG_W'(n_batt_mv) > i_thresh.low_mv) begin
                        n_class = KIND_LITHIUM;
                    end
                end
                res.update_millivolts = n_batt_mv;
            end else begin
                res.update_millivolts = i_q_mv;
            end
        end
        res.battery_kind     = n_class;
        res.battery_tracking = n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_cd[i] <= period_reset(i);
            end
            r_pending <= 1'b0;
            r_pend_ch <= '0;
            r_batt_mv <= '0;
            r_class   <= KIND_UNKNOWN;
            r_seen    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (advance) begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    r_cd[i] <= n_cd[i];
                end
                r_pending <= n_pending;
                r_pend_ch <= n_pend_ch;
                r_batt_mv <= n_batt_mv;
                r_class   <= n_class;
                r_seen    <= n_seen;
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    a_start_xor_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> !(r_out.start_conversion && r_out.update_valid))
        else $error("result both requests and updates");

    a_start_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && res.start_conversion) |=> r_pending)
        else $error("request did not mark a pending conversion");

    a_update_clears_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_pending) |=> !r_pending)
        else $error("pending conversion not cleared by its tick");

    a_seen_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen |=> r_seen)
        else $error("battery tracking flag dropped");

endmodule
`default_nettype wire

// ===== design/adc_poll_scheduler_slew_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adc_poll_scheduler_slew_filter_core: multi-rate converter poll scheduler
// one input transfer is one scheduler tick, one output transfer per tick
// ----------------------------------------------------------------------------
// path: a tick transfer is written into the tick queue, then the scheduler
//   update loads its result into the output register
// throughput: one tick per cycle while the result stream is accepted (i_m_tready)
// reset: synchronous active low, countdowns load their reset periods,
//   filter state and config registers reset, tick queue and output register empty
// ----------------------------------------------------------------------------
module adc_poll_scheduler_slew_filter_core #(
    parameter int NUM_CHANNELS   = aps_pkg::NUM_CHANNELS_DEF,
    parameter int REF_MILLIVOLTS = aps_pkg::REF_MV_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tick stream in
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    // [9:0] adc_code, [15:10] zero
    input  wire logic [aps_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // result stream out
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [0] start_conversion, [3:1] start_channel, [4] update_valid,
    // [7:5] update_channel, [20:8] update_millivolts, [22:21] battery_kind,
    // [23] battery_tracking
    output logic [aps_pkg::OUT_TDATA_W-1:0]          o_m_tdata,
    // config write channel
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [aps_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [aps_pkg::REG_W-1:0]           i_cfg_data
);
    import aps_pkg::*;

    // config registers
    logic [REG_W-1:0] r_period [NUM_PERIOD_REGS];
    t_thresh          r_thresh;
    logic             cfg_we;

    // channel periods seen by the scheduler
    logic [NUM_CHANNELS-1:0][REG_W-1:0] periods;

    // tick queue between front and back
    logic             q_valid;
    logic [MV_W-1:0]  q_mv;
    logic             q_pop;
    t_result          result;

    // writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_PERIOD_REGS; i++) begin
                r_period[i] <= period_reset(i);
            end
            r_thresh.jump_mv <= JUMP_MV_RST;
            r_thresh.high_mv <= HIGH_MV_RST;
            r_thresh.low_mv  <= LOW_MV_RST;
        end else if (cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index)) inside
                REG_PERIOD0, REG_PERIOD1, REG_PERIOD2, REG_PERIOD3, REG_PERIOD4: begin
                    r_period[i_cfg_index] <= i_cfg_data;
                end
                REG_JUMP: begin
                    r_thresh.jump_mv <= i_cfg_data;
                end
                REG_HIGH: begin
                    r_thresh.high_mv <= i_cfg_data;
                end
                REG_LOW: begin
                    r_thresh.low_mv <= i_cfg_data;
                end
            endcase
        end
    end

    // channels past the register file run at a fixed period
    for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_period
        if (g < NUM_PERIOD_REGS) begin : g_reg
            assign periods[g] = r_period[g];
        end else begin : g_fixed
            assign periods[g] = FIXED_PERIOD;
        end
    end

    // front: scale the code and queue the tick
    aps_front #(
        .REF_MILLIVOLTS (REF_MILLIVOLTS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_code     (i_s_tdata[CODE_W-1:0]),
        .i_pop      (q_pop),
        .o_q_valid  (q_valid),
        .o_q_mv     (q_mv)
    );

    // back: countdowns, conversion request, battery filter, output register
    aps_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_periods  (periods),
        .i_thresh   (r_thresh),
        .i_q_valid  (q_valid),
        .i_q_mv     (q_mv),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_result   (result)
    );

    assign o_m_tdata = result;

endmodule
`default_nettype wire
